[hw/rtl/u8u16_pkg.sv]
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// Holds the controller states, the command and status structs and the code constants.
// No dependencies.
package u8u16_pkg;

  localparam logic [15:0] REPLACEMENT = 16'hFFFD;
  localparam logic [20:0] MAX_SCALAR  = 21'h10FFFF;
  localparam logic [20:0] BMP_LIMIT   = 21'h00FFFF;
  localparam logic [20:0] PLANE_BASE  = 21'h010000;
  localparam logic [15:0] HIGH_BASE   = 16'hD800;
  localparam logic [15:0] LOW_BASE    = 16'hDC00;

  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_CODE  = 8'h80;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_UNIT,
    KIND_PAIR,
    KIND_BROKEN
  } kind_t;

  typedef enum logic [1:0] {
    SEL_PROC,
    SEL_LOW,
    SEL_HOLD,
    SEL_REPL
  } out_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOW,
    ST_REPLAY,
    ST_RLOW,
    ST_DONE,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic     take;
    logic     from_replay;
    logic     clear_window;
    logic     out_load;
    out_sel_t out_sel;
    logic     out_run_end;
    logic     out_text_end;
    logic     hold_load;
    logic     hold_from_low;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  replay_end;
    logic  replay_empty;
    logic  window_open;
    logic  out_free;
  } status_t;

endpackage

[hw/rtl/u8u16_dpath.sv]
// Datapath of the transcoder: decode window, replay buffer, hold and output registers.
// Driven by commands from u8u16_ctrl; depends on u8u16_pkg.
module u8u16_dpath (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         in_byte,
  input  u8u16_pkg::cmd_t    cmd,
  output u8u16_pkg::status_t status,
  input  logic               m_tready,
  output logic               m_tvalid,
  output logic [15:0]        m_tdata,
  output logic               m_tuser,
  output logic               m_tlast
);
  import u8u16_pkg::*;

  logic [7:0]  lead;
  logic [7:0]  wb [3];
  logic [1:0]  fill;
  logic [1:0]  need;
  logic [7:0]  rb [3];
  logic [1:0]  ri;
  logic [1:0]  rn;
  logic [15:0] low_unit;
  logic [15:0] hold_unit;
  logic        out_valid;
  logic [15:0] out_unit;
  logic        out_run_end;
  logic        out_text_end;

  logic [7:0]  x;
  logic [7:0]  c0, c1, c2;
  logic [1:0]  fill_inc;
  logic [1:0]  lead_need;
  logic        complete;
  logic        ok;
  logic [20:0] scalar;
  logic [20:0] v;
  logic [15:0] high;
  logic [15:0] low;
  logic [15:0] proc_unit;
  kind_t       kind;
  logic        out_free;

  always_comb begin
    unique case (ri)
      2'd0:    x = rb[0];
      2'd1:    x = rb[1];
      default: x = rb[2];
    endcase
    if (ri == rn) begin
      x = in_byte;
    end
  end

  assign c0 = (fill == 2'd0) ? x : wb[0];
  assign c1 = (fill == 2'd1) ? x : wb[1];
  assign c2 = (fill == 2'd2) ? x : wb[2];
  assign fill_inc = fill + 2'd1;
  assign complete = (need != 2'd0) && (fill_inc == need);

  always_comb begin
    if ((x & LEAD2_MASK) == LEAD2_CODE) begin
      lead_need = 2'd1;
    end else if ((x & LEAD3_MASK) == LEAD3_CODE) begin
      lead_need = 2'd2;
    end else if ((x & LEAD4_MASK) == LEAD4_CODE) begin
      lead_need = 2'd3;
    end else begin
      lead_need = 2'd0;
    end
  end

  always_comb begin
    unique case (need)
      2'd1: begin
        ok     = (c0 & CONT_MASK) == CONT_CODE;
        scalar = {10'd0, lead[4:0], c0[5:0]};
      end
      2'd2: begin
        ok     = ((c0 & CONT_MASK) == CONT_CODE) && ((c1 & CONT_MASK) == CONT_CODE);
        scalar = {5'd0, lead[3:0], c0[5:0], c1[5:0]};
      end
      default: begin
        ok     = ((c0 & CONT_MASK) == CONT_CODE) && ((c1 & CONT_MASK) == CONT_CODE)
                 && ((c2 & CONT_MASK) == CONT_CODE);
        scalar = {lead[2:0], c0[5:0], c1[5:0], c2[5:0]};
      end
    endcase
  end

  assign v    = scalar - PLANE_BASE;
  assign high = HIGH_BASE + {6'd0, v[19:10]};
  assign low  = LOW_BASE + {6'd0, v[9:0]};

  always_comb begin
    kind      = KIND_NONE;
    proc_unit = REPLACEMENT;
    if (need == 2'd0) begin
      if (!x[7]) begin
        kind      = KIND_UNIT;
        proc_unit = {8'd0, x};
      end else if (lead_need == 2'd0) begin
        kind = KIND_UNIT;
      end
    end else if (complete) begin
      if (!ok) begin
        kind = KIND_BROKEN;
      end else if (scalar > MAX_SCALAR) begin
        kind = KIND_UNIT;
      end else if (scalar > BMP_LIMIT) begin
        kind      = KIND_PAIR;
        proc_unit = high;
      end else begin
        kind      = KIND_UNIT;
        proc_unit = scalar[15:0];
      end
    end
  end

  assign out_free = !out_valid || m_tready;

  assign status.kind         = kind;
  assign status.replay_end   = (kind != KIND_BROKEN) && ((ri + 2'd1) == rn);
  assign status.replay_empty = ri == rn;
  assign status.window_open  = need != 2'd0;
  assign status.out_free     = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
      need <= 2'd0;
      ri   <= 2'd0;
      rn   <= 2'd0;
    end else begin
      if (cmd.take) begin
        if (need == 2'd0) begin
          if (lead_need != 2'd0) begin
            need <= lead_need;
            fill <= 2'd0;
          end
        end else if (complete) begin
          need <= 2'd0;
          fill <= 2'd0;
        end else begin
          fill <= fill_inc;
        end
        if (cmd.from_replay) begin
          if (kind == KIND_BROKEN) begin
            ri <= ri + 2'd1 - need;
          end else begin
            ri <= ri + 2'd1;
          end
        end else if (kind == KIND_BROKEN) begin
          ri <= 2'd0;
          rn <= need;
        end
      end
      if (cmd.clear_window) begin
        need <= 2'd0;
        fill <= 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      if (need == 2'd0) begin
        if (lead_need != 2'd0) begin
          lead <= x;
        end
      end else begin
        unique case (fill)
          2'd0:    wb[0] <= x;
          2'd1:    wb[1] <= x;
          default: wb[2] <= x;
        endcase
      end
      if (!cmd.from_replay && kind == KIND_BROKEN) begin
        rb[0] <= c0;
        rb[1] <= c1;
        rb[2] <= c2;
      end
      if (kind == KIND_PAIR) begin
        low_unit <= low;
      end
    end
    if (cmd.hold_load) begin
      hold_unit <= cmd.hold_from_low ? low_unit : proc_unit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_run_end  <= cmd.out_run_end;
      out_text_end <= cmd.out_text_end;
      unique case (cmd.out_sel)
        SEL_PROC: out_unit <= proc_unit;
        SEL_LOW:  out_unit <= low_unit;
        SEL_HOLD: out_unit <= hold_unit;
        SEL_REPL: out_unit <= REPLACEMENT;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_unit;
  assign m_tuser  = out_run_end;
  assign m_tlast  = out_text_end;

endmodule

[hw/rtl/u8u16_ctrl.sv]
// Controller of the transcoder: sequences input beats, surrogate halves and replays.
// Issues commands to u8u16_dpath; depends on u8u16_pkg.
module u8u16_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_tlast,
  output logic               s_tready,
  input  u8u16_pkg::status_t status,
  output u8u16_pkg::cmd_t    cmd
);
  import u8u16_pkg::*;

  state_t state;
  state_t state_next;
  logic   step_fin;
  logic   accept;
  logic   flush_now;

  assign s_tready  = (state == ST_IDLE) && status.out_free;
  assign accept    = s_tready && s_tvalid;
  assign flush_now = step_fin && status.window_open;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_fin <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        step_fin <= s_tlast;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && status.kind == KIND_PAIR) begin
          state_next = ST_LOW;
        end else if (accept && status.kind == KIND_BROKEN) begin
          state_next = ST_REPLAY;
        end
      end
      ST_LOW: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_REPLAY: begin
        if (status.out_free) begin
          if (status.kind == KIND_PAIR) begin
            state_next = ST_RLOW;
          end else if (status.replay_end) begin
            state_next = ST_DONE;
          end
        end
      end
      ST_RLOW: begin
        if (status.out_free) begin
          state_next = status.replay_empty ? ST_DONE : ST_REPLAY;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          state_next = flush_now ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.take = 1'b1;
          unique case (status.kind)
            KIND_UNIT: begin
              cmd.out_load     = 1'b1;
              cmd.out_sel      = SEL_PROC;
              cmd.out_run_end  = 1'b1;
              cmd.out_text_end = s_tlast;
            end
            KIND_NONE: begin
              if (s_tlast) begin
                cmd.clear_window = 1'b1;
                cmd.out_load     = 1'b1;
                cmd.out_sel      = SEL_REPL;
                cmd.out_run_end  = 1'b1;
                cmd.out_text_end = 1'b1;
              end
            end
            KIND_PAIR: begin
              cmd.out_load = 1'b1;
              cmd.out_sel  = SEL_PROC;
            end
            KIND_BROKEN: begin
              cmd.hold_load = 1'b1;
            end
          endcase
        end
      end
      ST_LOW: begin
        if (status.out_free) begin
          cmd.out_load     = 1'b1;
          cmd.out_sel      = SEL_LOW;
          cmd.out_run_end  = 1'b1;
          cmd.out_text_end = step_fin;
        end
      end
      ST_REPLAY: begin
        if (status.out_free) begin
          cmd.take        = 1'b1;
          cmd.from_replay = 1'b1;
          if (status.kind != KIND_NONE) begin
            cmd.out_load  = 1'b1;
            cmd.out_sel   = SEL_HOLD;
            cmd.hold_load = 1'b1;
          end
        end
      end
      ST_RLOW: begin
        if (status.out_free) begin
          cmd.out_load      = 1'b1;
          cmd.out_sel       = SEL_HOLD;
          cmd.hold_load     = 1'b1;
          cmd.hold_from_low = 1'b1;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load     = 1'b1;
          cmd.out_sel      = SEL_HOLD;
          cmd.out_run_end  = !flush_now;
          cmd.out_text_end = step_fin && !status.window_open;
          cmd.clear_window = flush_now;
        end
      end
      ST_FLUSH: begin
        if (status.out_free) begin
          cmd.out_load     = 1'b1;
          cmd.out_sel      = SEL_REPL;
          cmd.out_run_end  = 1'b1;
          cmd.out_text_end = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

[hw/rtl/utf8_to_utf16_transcoder_unit.sv]
// Top level of the UTF-8 to UTF-16 transcoder.
// Joins u8u16_ctrl and u8u16_dpath; depends on u8u16_pkg.
//
// Input channel s_*: one UTF-8 byte per beat on s_tdata, s_tlast marks the last byte of a text.
// Output channel m_*: one UTF-16 code unit per beat on m_tdata; m_tuser marks the last unit
// caused by one input byte, m_tlast the last unit of the whole text.
// Units pass through the output register; a unit loaded by an accepted beat is on m_*
// in the cycle after that beat. Throughput: one byte per cycle while m_tready stays high and
// each byte causes at most one unit. A code point above U+FFFF leaves as two surrogate halves
// through the single output register; s_tready is low while ST_LOW sends the low half.
// A malformed window (a byte in it is not a continuation byte) puts U+FFFD in the hold register;
// the controller then walks the replay buffer one byte per cycle while the output register is
// free and closes the run in ST_DONE. A text that ends inside an open window yields one U+FFFD
// on its final beat. Reset clears the window, the replay state and the output register; the user
// must take care that no item is taken during reset, as the block does not enforce it. When the
// receiver stalls, the output beat holds and s_tready drops until the output register frees.
module utf8_to_utf16_transcoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  input  logic        s_tlast,   // final_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] code_unit
  output logic        m_tuser,   // [0] run_end
  output logic        m_tlast    // text_end
);
  import u8u16_pkg::*;

  cmd_t    cmd;
  status_t status;

  u8u16_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  u8u16_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .in_byte  (s_tdata),
    .cmd      (cmd),
    .status   (status),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

[hw/rtl/u8u16_checker.sv]
// Port-level checks for the transcoder, bound to utf8_to_utf16_transcoder_unit.
// Sees only the top-level ports; no package dependency.
module u8u16_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  a_text_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser)
    else $error("text end beat without run end");

  a_no_take_when_blocked: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while output stalled");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("output beat changed while stalled");

  a_final_gives_unit: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready || (m_tvalid && m_tlast))
    else $error("input ready after final byte without text end beat");

endmodule

bind utf8_to_utf16_transcoder_unit u8u16_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
